### rtl/tap_file_framer_top_macros.svh
// ---------------------------------------------------------------------------
// Tape file framer assertion macros
// Shared concurrent assertion wrappers; compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef TAP_FILE_FRAMER_TOP_MACROS_SVH
`define TAP_FILE_FRAMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define TFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Next-cycle implication, disabled during reset.
`define TFF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define TFF_ASSERT(label, prop, msg)
`define TFF_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### rtl/tff_pkg.sv
// ---------------------------------------------------------------------------
// Tape file framer package
// Command codes, job type, tape format constants and register indices.
// ---------------------------------------------------------------------------
`default_nettype none

package tff_pkg;

  // Input command codes (tuser)
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Configuration register indices
  localparam logic [1:0] REG_NAME_FIRST = 2'd0;
  localparam logic [1:0] REG_NAME_LAST  = 2'd1;
  localparam logic [1:0] REG_DATA_LEN   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [63:0] NAME_FIRST_RST = 64'h2020_2020_2020_2020;
  localparam logic [15:0] NAME_LAST_RST  = 16'h2020;
  localparam logic [15:0] DATA_LEN_RST   = 16'h0000;

  // Tape format
  localparam logic [7:0]  HDR_LEN    = 8'h13;
  localparam logic [7:0]  HDR_FLAG   = 8'h00;
  localparam logic [7:0]  TYPE_CODE  = 8'h03;
  localparam logic [15:0] LOAD_WORD  = 16'h0000;
  localparam logic [15:0] PARAM_WORD = 16'h8000;
  localparam logic [7:0]  DATA_FLAG  = 8'hFF;
  localparam int unsigned PRE_LEN    = 24;
  localparam int unsigned PRE_IDX_W  = $clog2(PRE_LEN);
  localparam logic [PRE_IDX_W-1:0] PRE_LAST_IDX = PRE_IDX_W'(PRE_LEN - 1);

  // Data byte counter
  localparam int unsigned CNT_W = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Job queue depth
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    JOB_PREAMBLE,
    JOB_DATA,
    JOB_FINISH
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] byte_val;  // data byte or closing checksum
    logic       cnt_err;   // count mismatch, finish only
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

### rtl/tff_front.sv
// ---------------------------------------------------------------------------
// Tape file framer front end
// Classifies input commands, tracks file state and checksum, emits jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module tff_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   cmd_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic [15:0]  data_len_i,
  input  wire tff_pkg::queue_stat_t q_stat_i,
  output logic              push_o,
  output tff_pkg::job_t     job_o
);
  import tff_pkg::*;

  logic             open_q, open_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       xor_q, xor_d;
  logic             accept;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    open_d         = open_q;
    count_d        = count_q;
    xor_d          = xor_q;
    push_o         = 1'b0;
    job_o.kind     = JOB_PREAMBLE;
    job_o.byte_val = data_byte_i;
    job_o.cnt_err  = 1'b0;
    if (accept) begin
      case (cmd_i)
        CMD_START: begin
          // a start abandons any open file
          push_o  = 1'b1;
          open_d  = 1'b1;
          count_d = '0;
          xor_d   = DATA_FLAG;
        end
        CMD_DATA: begin
          if (open_q) begin
            push_o     = 1'b1;
            job_o.kind = JOB_DATA;
            xor_d      = xor_q ^ data_byte_i;
            if (count_q != COUNT_MAX) begin
              count_d = count_q + CNT_W'(1);
            end
          end
        end
        CMD_FINISH: begin
          if (open_q) begin
            push_o         = 1'b1;
            job_o.kind     = JOB_FINISH;
            job_o.byte_val = xor_q;
            job_o.cnt_err  = (count_q != {1'b0, data_len_i});
            open_d         = 1'b0;
          end
        end
        default: begin
          // unused command: dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      count_q <= '0;
      xor_q   <= '0;
    end else begin
      open_q  <= open_d;
      count_q <= count_d;
      xor_q   <= xor_d;
    end
  end

endmodule

`default_nettype wire

### rtl/tff_job_queue.sv
// ---------------------------------------------------------------------------
// Tape file framer job queue
// Small register FIFO between front end and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tff_job_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tff_pkg::job_t   job_i,
  input  wire logic            pop_i,
  output tff_pkg::job_t        head_o,
  output tff_pkg::queue_stat_t stat_o
);
  import tff_pkg::*;

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign stat_o  = '{full: (cnt_q == QCNT_W'(QUEUE_DEPTH)), empty: (cnt_q == '0)};
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tff_back.sv
// ---------------------------------------------------------------------------
// Tape file framer back end
// Expands jobs into output-register tape bytes, one per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module tff_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire tff_pkg::job_t job_i,
  output logic               pop_o,
  input  wire logic [63:0]   name_first_i,
  input  wire logic [15:0]   name_last_i,
  input  wire logic [15:0]   data_len_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic               out_eof_o,
  output logic               out_err_o
);
  import tff_pkg::*;

  logic [PRE_IDX_W-1:0] idx_q, idx_d;
  logic                 valid_q, valid_d;
  logic [7:0]           byte_q, byte_d;
  logic                 last_q, last_d;
  logic                 eof_q, eof_d;
  logic                 err_q, err_d;
  logic                 load;
  logic                 job_last;
  logic [7:0]           hdr_sum;
  logic [15:0]          blk_len;
  logic [7:0]           pre_byte;

  assign blk_len = data_len_i + 16'd2;

  // header checksum: flag through the last word
  always_comb begin
    hdr_sum = HDR_FLAG ^ TYPE_CODE ^ name_last_i[7:0] ^ name_last_i[15:8]
            ^ data_len_i[7:0] ^ data_len_i[15:8]
            ^ LOAD_WORD[7:0] ^ LOAD_WORD[15:8] ^ PARAM_WORD[7:0] ^ PARAM_WORD[15:8];
    for (int i = 0; i < 8; i++) begin
      hdr_sum = hdr_sum ^ name_first_i[8*i +: 8];
    end
  end

  always_comb begin
    case (idx_q)
      5'd0:    pre_byte = HDR_LEN;
      5'd1:    pre_byte = 8'h00;
      5'd2:    pre_byte = HDR_FLAG;
      5'd3:    pre_byte = TYPE_CODE;
      5'd4:    pre_byte = name_first_i[7:0];
      5'd5:    pre_byte = name_first_i[15:8];
      5'd6:    pre_byte = name_first_i[23:16];
      5'd7:    pre_byte = name_first_i[31:24];
      5'd8:    pre_byte = name_first_i[39:32];
      5'd9:    pre_byte = name_first_i[47:40];
      5'd10:   pre_byte = name_first_i[55:48];
      5'd11:   pre_byte = name_first_i[63:56];
      5'd12:   pre_byte = name_last_i[7:0];
      5'd13:   pre_byte = name_last_i[15:8];
      5'd14:   pre_byte = data_len_i[7:0];
      5'd15:   pre_byte = data_len_i[15:8];
      5'd16:   pre_byte = LOAD_WORD[7:0];
      5'd17:   pre_byte = LOAD_WORD[15:8];
      5'd18:   pre_byte = PARAM_WORD[7:0];
      5'd19:   pre_byte = PARAM_WORD[15:8];
      5'd20:   pre_byte = hdr_sum;
      5'd21:   pre_byte = blk_len[7:0];
      5'd22:   pre_byte = blk_len[15:8];
      5'd23:   pre_byte = DATA_FLAG;
      default: pre_byte = 8'h00;
    endcase
  end

  assign load     = job_valid_i && (!valid_q || out_ready_i);
  assign job_last = (job_i.kind != JOB_PREAMBLE) || (idx_q == PRE_LAST_IDX);
  assign pop_o    = load && job_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    eof_d   = eof_q;
    err_d   = err_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      last_d  = job_last;
      eof_d   = (job_i.kind == JOB_FINISH);
      err_d   = job_i.cnt_err && (job_i.kind == JOB_FINISH);
      byte_d  = (job_i.kind == JOB_PREAMBLE) ? pre_byte : job_i.byte_val;
      if (job_i.kind == JOB_PREAMBLE) begin
        idx_d = job_last ? '0 : idx_q + PRE_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    eof_q  <= eof_d;
    err_q  <= err_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_eof_o   = eof_q;
  assign out_err_o   = err_q;

endmodule

`default_nettype wire

### rtl/tap_file_framer_top.sv
// ---------------------------------------------------------------------------
// Tape file framer top level
// Wraps a code image as a two-block tape file on a byte stream.
// ---------------------------------------------------------------------------
// A start transaction (tuser = 0) produces the 24-byte preamble: header
// block (length, flag, type, ten name bytes, data length, load and param
// words, header checksum) followed by the data block length and flag 0xFF.
// Data transactions (tuser = 1) echo their byte and fold it into the data
// checksum; a finish transaction (tuser = 2) emits that checksum with
// end-of-file set in m_axis_tuser[0] and a count mismatch in m_axis_tuser[1].
// Data and finish while no file is open, and tuser = 3, are accepted and
// dropped. tlast marks the final byte caused by each input transaction.
// Rate: the back end drives one output byte per cycle while jobs are queued
// and m_axis_tready holds; a data or finish transaction yields one byte and
// a start transaction 24. An accepted job is first written into the job
// queue and then loaded into the output register once that register is free.
// A two-entry job queue lets the input side keep accepting while a preamble
// is streaming out; s_axis_tready drops only when that queue is full.
// The user must write cfg_* configuration only while idle; the block does
// not enforce it. cfg_ready_o stays high; unknown-index writes are ignored.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tap_file_framer_top_macros.svh"

module tap_file_framer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // last_of_run
  output logic [1:0]       m_axis_tuser    // [0] end_of_file, [1] count_error
);
  import tff_pkg::*;

  // configuration registers
  logic [63:0] name_first_q;
  logic [15:0] name_last_q;
  logic [15:0] data_len_q;

  // front to back path
  logic        q_push;
  logic        q_pop;
  job_t        q_job_in;
  job_t        q_head;
  queue_stat_t q_stat;
  logic        cfg_wr;

  logic        out_eof;
  logic        out_err;
  logic        err_flag_ok;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_first_q <= NAME_FIRST_RST;
      name_last_q  <= NAME_LAST_RST;
      data_len_q   <= DATA_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_NAME_FIRST: name_first_q <= cfg_data_i;
        REG_NAME_LAST:  name_last_q  <= cfg_data_i[15:0];
        REG_DATA_LEN:   data_len_q   <= cfg_data_i[15:0];
        default: begin
          // unknown index: no effect
        end
      endcase
    end
  end

  // front end: file state, byte count, running checksum
  tff_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .data_len_i  (data_len_q),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .job_o       (q_job_in)
  );

  tff_job_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job_in),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // back end: byte sequencer and output register
  tff_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!q_stat.empty),
    .job_i        (q_head),
    .pop_o        (q_pop),
    .name_first_i (name_first_q),
    .name_last_i  (name_last_q),
    .data_len_i   (data_len_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_eof_o    (out_eof),
    .out_err_o    (out_err)
  );

  assign m_axis_tuser = {out_err, out_eof};

  // a count error only rides on the closing checksum, which ends its run
  assign err_flag_ok = !out_err || (out_eof && m_axis_tlast);

  // checks
  `TFF_ASSERT(a_queue_stat, !(q_stat.full && q_stat.empty), "queue both full and empty")
  `TFF_ASSERT(a_no_push_full, q_push |-> !q_stat.full, "job pushed into full queue")
  `TFF_ASSERT(a_err_at_eof, m_axis_tvalid |-> err_flag_ok, "count error outside checksum")
  `TFF_ASSERT_NEXT(a_push_not_empty, q_push && !q_pop, !q_stat.empty, "pushed job lost")

endmodule

`default_nettype wire
